// ===== sv/pqsc_pkg.sv =====
// package for the packet queue with source counters
// types, codes and constants shared by the controller, datapath and top level of the block
`timescale 1ns / 1ps

package pqsc_pkg;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_TOO_LONG = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  localparam logic [4:0] HIGH_WATER_RESET = 5'd19;

  typedef struct packed {
    op_e        op;
    logic [7:0] source_addr;
    logic [7:0] packet_length;
    logic [7:0] data_byte;
    logic       last;
    logic [2:0] entry_index;
  } in_item_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] out_byte;
    logic [7:0] out_source;
    logic [7:0] out_length;
    logic       end_of_packet;
    logic [4:0] occupancy;
    logic       over_threshold;
    logic [7:0] entry_addr;
    logic [7:0] entry_count;
    logic [3:0] modules_known;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic latch;  // capture the input beat and, for a pop, start the ram reads
    logic exec;   // commit the step and load the result register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_blocked;  // result register full and stalled
  } dp_status_t;

endpackage

// ===== sv/pqsc_ram.sv =====
// generic simple dual port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module pqsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/pqsc_ctrl.sv =====
// controller state machine: accept a beat, then execute it once the result
// register is free; depends on pqsc_pkg
`timescale 1ns / 1ps

module pqsc_ctrl
  import pqsc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  dp_status_t sts_i,
  output ctrl_cmd_t  cmd_o,
  output logic       in_stall_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!sts_i.out_blocked) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o  = 1'b0;
        cmd_o.latch = in_valid_i;
      end
      S_EXEC: begin
        cmd_o.exec = !sts_i.out_blocked;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/pqsc_dp.sv =====
// datapath: ring pointers, slot rams, counter table, result register
// depends on pqsc_pkg and pqsc_ram
`timescale 1ns / 1ps

module pqsc_dp
  import pqsc_pkg::*;
#(
  parameter int QUEUE_SLOTS    = 32,
  parameter int SLOT_BYTES     = 128,
  parameter int MODULE_ENTRIES = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctrl_cmd_t  cmd_i,
  output dp_status_t sts_o,
  input  in_item_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_data_o,
  input  logic       cfg_valid_i,
  input  logic [4:0] cfg_data_i
);

  localparam int PW  = $clog2(QUEUE_SLOTS);
  localparam int BAW = $clog2(QUEUE_SLOTS * SLOT_BYTES);
  localparam int KW  = $clog2(MODULE_ENTRIES + 1);

  in_item_t        item_q;
  out_item_t       out_q, out_d;
  logic            out_valid_q, out_valid_d;
  logic [PW-1:0]   head_q, head_d, tail_q, tail_d;
  logic [7:0]      wr_idx_q, wr_idx_d, rd_idx_q, rd_idx_d;
  logic            receiving_q, receiving_d, dropping_q, dropping_d;
  logic [7:0]      cur_len_q, cur_len_d, cur_src_q, cur_src_d;
  logic [7:0]      mod_addr_q [MODULE_ENTRIES];
  logic [7:0]      mod_addr_d [MODULE_ENTRIES];
  logic [7:0]      mod_cnt_q  [MODULE_ENTRIES];
  logic [7:0]      mod_cnt_d  [MODULE_ENTRIES];
  logic [KW-1:0]   known_q, known_d;
  logic [4:0]      hw_q;

  // ram ports
  logic            byte_we, meta_we, rd_en;
  logic [BAW-1:0]  byte_waddr, byte_raddr;
  logic [7:0]      byte_wdata, byte_rdata;
  logic [15:0]     meta_wdata, meta_rdata;

  // step temporaries
  logic            first, found;
  logic [7:0]      eff_len, eff_src, widx, widx_n, pop_len, pop_src;
  logic            eop;
  logic [PW:0]     occ;

  function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
    return (32'(p) == QUEUE_SLOTS - 1) ? '0 : p + PW'(1);
  endfunction

  assign rd_en      = cmd_i.latch && (in_data_i.op == OP_POP);
  assign byte_raddr = BAW'(head_q) * BAW'(SLOT_BYTES) + BAW'(rd_idx_q);
  assign pop_src    = meta_rdata[15:8];
  assign pop_len    = meta_rdata[7:0];

  pqsc_ram #(.WIDTH(8), .DEPTH(QUEUE_SLOTS * SLOT_BYTES)) u_byte_ram (
    .clk_i   (clk_i),
    .we_i    (byte_we),
    .waddr_i (byte_waddr),
    .wdata_i (byte_wdata),
    .re_i    (rd_en),
    .raddr_i (byte_raddr),
    .rdata_o (byte_rdata)
  );

  // slot metadata: source in the high byte, stored length in the low byte
  pqsc_ram #(.WIDTH(16), .DEPTH(QUEUE_SLOTS)) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (tail_q),
    .wdata_i (meta_wdata),
    .re_i    (rd_en),
    .raddr_i (head_q),
    .rdata_o (meta_rdata)
  );

  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    wr_idx_d    = wr_idx_q;
    rd_idx_d    = rd_idx_q;
    receiving_d = receiving_q;
    dropping_d  = dropping_q;
    cur_len_d   = cur_len_q;
    cur_src_d   = cur_src_q;
    mod_addr_d  = mod_addr_q;
    mod_cnt_d   = mod_cnt_q;
    known_d     = known_q;
    byte_we     = 1'b0;
    meta_we     = 1'b0;
    first       = !receiving_q;
    eff_len     = first ? item_q.packet_length : cur_len_q;
    eff_src     = first ? item_q.source_addr : cur_src_q;
    widx        = first ? 8'd0 : wr_idx_q;
    widx_n      = widx;
    byte_waddr  = BAW'(tail_q) * BAW'(SLOT_BYTES) + BAW'(widx);
    byte_wdata  = item_q.data_byte;
    meta_wdata  = '0;
    eop         = (9'(rd_idx_q) + 9'd1) >= 9'(pop_len);
    found       = 1'b0;
    out_d       = '0;
    out_d.status = ST_OK;

    case (item_q.op)
      OP_PUSH: begin
        if (dropping_q) begin
          if (item_q.last) begin
            dropping_d = 1'b0;
          end
        end else begin
          if (first && (next_slot(tail_q) == head_q)) begin
            out_d.status = ST_FULL;
          end else if (first && (9'(item_q.packet_length) > 9'(SLOT_BYTES))) begin
            out_d.status = ST_TOO_LONG;
          end
          if (out_d.status != ST_OK) begin
            dropping_d = !item_q.last;
          end else begin
            // ram writes only on the commit cycle
            if (widx < eff_len) begin
              byte_we = cmd_i.exec;
              widx_n  = widx + 8'd1;
            end
            if (item_q.last) begin
              meta_we     = cmd_i.exec;
              meta_wdata  = {eff_src, widx_n};
              tail_d      = next_slot(tail_q);
              receiving_d = 1'b0;
              wr_idx_d    = 8'd0;
            end else begin
              receiving_d = 1'b1;
              wr_idx_d    = widx_n;
              cur_len_d   = eff_len;
              cur_src_d   = eff_src;
            end
          end
        end
      end
      OP_POP: begin
        if (head_q == tail_q) begin
          out_d.status = ST_EMPTY;
        end else begin
          out_d.out_byte      = (rd_idx_q < pop_len) ? byte_rdata : 8'd0;
          out_d.out_source    = pop_src;
          out_d.out_length    = pop_len;
          out_d.end_of_packet = eop;
          if (eop) begin
            head_d   = next_slot(head_q);
            rd_idx_d = 8'd0;
            // first entry that is free or already holds this source
            if (pop_src != 8'd0) begin
              for (int i = 0; i < MODULE_ENTRIES; i++) begin
                if (!found && (mod_addr_q[i] == 8'd0 || mod_addr_q[i] == pop_src)) begin
                  found        = 1'b1;
                  mod_cnt_d[i] = mod_cnt_q[i] + 8'd1;
                  if (mod_addr_q[i] == 8'd0) begin
                    mod_addr_d[i] = pop_src;
                    known_d       = known_q + KW'(1);
                  end
                end
              end
            end
          end else begin
            rd_idx_d = rd_idx_q + 8'd1;
          end
        end
      end
      OP_READ: begin
        for (int i = 0; i < MODULE_ENTRIES; i++) begin
          if (32'(item_q.entry_index) == i) begin
            out_d.entry_addr  = mod_addr_q[i];
            out_d.entry_count = mod_cnt_q[i];
          end
        end
      end
      default: begin
        for (int i = 0; i < MODULE_ENTRIES; i++) begin
          mod_cnt_d[i] = 8'd0;
        end
      end
    endcase

    // occupancy after the step
    if (tail_d >= head_d) begin
      occ = (PW+1)'(tail_d) - (PW+1)'(head_d);
    end else begin
      occ = (PW+1)'(tail_d) + (PW+1)'(QUEUE_SLOTS) - (PW+1)'(head_d);
    end
    out_d.occupancy      = 5'(occ);
    out_d.over_threshold = 9'(occ) > 9'(hw_q);
    out_d.modules_known  = 4'(known_d);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.exec) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign sts_o.out_blocked = out_valid_q && out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      head_q      <= '0;
      tail_q      <= '0;
      wr_idx_q    <= '0;
      rd_idx_q    <= '0;
      receiving_q <= 1'b0;
      dropping_q  <= 1'b0;
      mod_addr_q  <= '{default: '0};
      mod_cnt_q   <= '{default: '0};
      known_q     <= '0;
      hw_q        <= HIGH_WATER_RESET;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        hw_q <= cfg_data_i;
      end
      if (cmd_i.exec) begin
        head_q      <= head_d;
        tail_q      <= tail_d;
        wr_idx_q    <= wr_idx_d;
        rd_idx_q    <= rd_idx_d;
        receiving_q <= receiving_d;
        dropping_q  <= dropping_d;
        mod_addr_q  <= mod_addr_d;
        mod_cnt_q   <= mod_cnt_d;
        known_q     <= known_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      item_q <= in_data_i;
    end
    if (cmd_i.exec) begin
      out_q     <= out_d;
      cur_len_q <= cur_len_d;
      cur_src_q <= cur_src_d;
    end
  end

endmodule

// ===== sv/packet_queue_with_source_counters.sv =====
// top level of the packet queue with per-source counters
// depends on pqsc_pkg, pqsc_ctrl, pqsc_dp (and through it pqsc_ram)
`timescale 1ns / 1ps
//
// usage
// - input channel: one beat per operation (push byte, pop byte, read a
//   counter entry, clear counts), valid with stall driven by this block
// - output channel: exactly one result beat per input beat, in order,
//   valid with stall driven by the receiver
// - config channel: one write-only register (high-water mark), valid and
//   ready, ready is always high; write it only while the block is idle
// - timing: a beat is taken in the idle state and executed in the execute
//   state, since the slot rams have a registered read; a new beat is not
//   taken until the previous one has executed, and the result is loaded
//   into the output register when its beat executes
// - a finished result waits in the output register while the next beat is
//   taken; if the receiver still stalls when that beat is ready to commit,
//   execution holds (and input stays stalled) until the result is taken
// - reset: pointers, counter table, packet state and the result valid flag
//   clear at once, the high-water mark returns to 19; slot contents are
//   not cleared, so the block is ready right after reset
//
module packet_queue_with_source_counters
  import pqsc_pkg::*;
#(
  parameter int QUEUE_SLOTS    = 32,
  parameter int SLOT_BYTES     = 128,
  parameter int MODULE_ENTRIES = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input beats
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_data_i,
  // result beats
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_data_o,
  // high-water register write
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [4:0] cfg_data_i
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  // register write never waits
  assign cfg_ready_o = 1'b1;

  // sequencer: idle (taking beats) and execute (commit into result register)
  pqsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  // ring state, slot rams, counter table and result register
  pqsc_dp #(
    .QUEUE_SLOTS    (QUEUE_SLOTS),
    .SLOT_BYTES     (SLOT_BYTES),
    .MODULE_ENTRIES (MODULE_ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // one beat in flight: a taken beat blocks the input until it commits
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken twice in a row");

  // never commit into a stalled full result register
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.exec |-> !(out_valid_o && out_stall_i))
    else $error("result overwritten while stalled");

  // a failed step carries no packet byte and no end of packet
  a_pop_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |->
      out_data_o.out_byte == 8'd0 && out_data_o.end_of_packet == 1'b0)
    else $error("packet fields set on a failed step");

endmodule

// ===== sim/testbench.sv =====
// self-checking bench for packet_queue_with_source_counters
// needs pqsc_pkg and the block's rtl; mirrors the queue and counter table in its own model
`timescale 1ns / 1ps

module testbench;
  import pqsc_pkg::*;

  localparam int HALF_PERIOD = 5;
  localparam int RING_SLOTS  = 32;
  localparam int SLOT_LIMIT  = 128;
  localparam int TABLE_SIZE  = 8;
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int STALL_LIMIT = 4000;  // cycles with no handshake at all
  localparam logic [7:0] SOURCE_POOL [12] = '{8'h00, 8'h01, 8'h02, 8'h03, 8'h40, 8'h7f,
                                              8'h80, 8'hc3, 8'hfe, 8'hff, 8'h11, 8'h22};

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [4:0] cfg_data = '0;

  always #HALF_PERIOD clk = ~clk;

  packet_queue_with_source_counters i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  // queue model: ring of slots, one always left empty
  bit [7:0]   slot_data [RING_SLOTS][SLOT_LIMIT];
  bit [7:0]   slot_len  [RING_SLOTS];
  bit [7:0]   slot_src  [RING_SLOTS];
  bit [4:0]   head_ptr, tail_ptr;  // 32 slots, so 5-bit pointers wrap on their own
  int         wr_idx, rd_idx;
  bit         receiving, dropping;
  bit [7:0]   src_addr  [TABLE_SIZE];
  bit [7:0]   src_count [TABLE_SIZE];
  int         known_sources;
  logic [4:0] high_water = HIGH_WATER_RESET;

  out_item_t queued_answers [$];
  bit  idle_on = 1'b1;
  int  hold_requests, holds_served, hold_left;
  int  beats_sent, results_checked, error_count;
  int  packets_popped, pushes_refused, peak_occupancy;

  // advance the queue model by one beat and return the result it must produce
  function automatic out_item_t step_packet_queue(input in_item_t beat);
    out_item_t r;
    bit [7:0]  len;
    bit [7:0]  src;
    bit        counted;
    r = '0;
    case (beat.op)
      OP_PUSH: begin
        if (dropping) begin
          // rest of a refused packet, swallowed up to its last beat
          if (beat.last) dropping = 1'b0;
        end else begin
          if (!receiving) begin
            if (tail_ptr + 5'd1 == head_ptr) r.status = ST_FULL;
            else if (beat.packet_length > SLOT_LIMIT) r.status = ST_TOO_LONG;
            if (r.status != ST_OK) begin
              pushes_refused++;
              if (!beat.last) dropping = 1'b1;
            end else begin
              slot_src[tail_ptr] = beat.source_addr;
              slot_len[tail_ptr] = beat.packet_length;
              wr_idx = 0;
              receiving = 1'b1;
            end
          end
          if (receiving) begin
            // bytes past the declared length are dropped
            if (wr_idx < slot_len[tail_ptr]) begin
              slot_data[tail_ptr][wr_idx] = beat.data_byte;
              wr_idx++;
            end
            // early last shrinks the stored length to what arrived
            if (beat.last) begin
              slot_len[tail_ptr] = 8'(wr_idx);
              tail_ptr = tail_ptr + 5'd1;
              receiving = 1'b0;
              wr_idx = 0;
            end
          end
        end
      end
      OP_POP: begin
        if (head_ptr == tail_ptr) begin
          r.status = ST_EMPTY;
        end else begin
          len = slot_len[head_ptr];
          src = slot_src[head_ptr];
          if (rd_idx < len) r.out_byte = slot_data[head_ptr][rd_idx];
          r.out_source = src;
          r.out_length = len;
          r.end_of_packet = (rd_idx + 1 >= len);
          if (r.end_of_packet) begin
            packets_popped++;
            // source zero is never counted, unknown sources need a free entry
            counted = (src == 8'd0);
            for (int i = 0; i < TABLE_SIZE && !counted; i++) begin
              if (src_addr[i] == 8'd0) begin
                src_addr[i] = src;
                src_count[i] = src_count[i] + 8'd1;
                known_sources++;
                counted = 1'b1;
              end else if (src_addr[i] == src) begin
                src_count[i] = src_count[i] + 8'd1;
                counted = 1'b1;
              end
            end
            head_ptr = head_ptr + 5'd1;
            rd_idx = 0;
          end else begin
            rd_idx++;
          end
        end
      end
      OP_READ: begin
        r.entry_addr = src_addr[beat.entry_index];
        r.entry_count = src_count[beat.entry_index];
      end
      default: begin
        // addresses stay claimed, only the counts go
        foreach (src_count[i]) src_count[i] = 8'd0;
      end
    endcase
    r.occupancy = tail_ptr - head_ptr;
    r.over_threshold = (r.occupancy > high_water);
    r.modules_known = 4'(known_sources);
    if (r.occupancy > peak_occupancy) peak_occupancy = r.occupancy;
    return r;
  endfunction

  function automatic in_item_t make_beat(input op_e op, input logic [7:0] src,
                                         input logic [7:0] len, input logic [7:0] data,
                                         input logic last, input logic [2:0] idx);
    in_item_t b;
    b.op = op;
    b.source_addr = src;
    b.packet_length = len;
    b.data_byte = data;
    b.last = last;
    b.entry_index = idx;
    return b;
  endfunction

  function automatic in_item_t random_beat();
    logic [$bits(in_item_t)-1:0] raw;
    raw = $bits(in_item_t)'($urandom);
    return in_item_t'(raw);
  endfunction

  function automatic void compare_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  // drive one beat, hold it until taken, then log what it must produce
  task automatic send_beat(input in_item_t beat);
    if (idle_on) begin
      while ($urandom_range(99) < 24) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    queued_answers.push_back(step_packet_queue(beat));
    beats_sent++;
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (queued_answers.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_high_water(input logic [4:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    high_water = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // corner cases one beat at a time
  task automatic test_directed();
    write_high_water(5'd0);
    send_beat(make_beat(OP_POP, 8'h00, 8'h00, 8'h00, 1'b0, 3'd0));   // empty ring
    send_beat(make_beat(OP_READ, 8'hff, 8'hff, 8'hff, 1'b1, 3'd7));
    // zero-length packet from source zero
    send_beat(make_beat(OP_PUSH, 8'h00, 8'h00, 8'hff, 1'b1, 3'd0));
    send_beat(make_beat(OP_POP, 8'h00, 8'h00, 8'h00, 1'b0, 3'd0));
    send_beat(make_beat(OP_PUSH, 8'hff, 8'd3, 8'h00, 1'b0, 3'd0));
    send_beat(make_beat(OP_PUSH, 8'hff, 8'd3, 8'hff, 1'b0, 3'd0));
    send_beat(make_beat(OP_PUSH, 8'hff, 8'd3, 8'ha5, 1'b1, 3'd0));
    repeat (3) send_beat(make_beat(OP_POP, 8'h00, 8'h00, 8'h00, 1'b0, 3'd0));
    // too long: refused on the first beat, the rest is swallowed
    send_beat(make_beat(OP_PUSH, 8'h12, 8'd129, 8'h01, 1'b0, 3'd0));
    send_beat(make_beat(OP_PUSH, 8'h12, 8'd129, 8'h02, 1'b0, 3'd0));
    send_beat(make_beat(OP_PUSH, 8'h12, 8'd129, 8'h03, 1'b1, 3'd0));
    send_beat(make_beat(OP_PUSH, 8'h34, 8'd255, 8'h04, 1'b1, 3'd0));
    // last before the declared length
    send_beat(make_beat(OP_PUSH, 8'h56, 8'd5, 8'h10, 1'b0, 3'd0));
    send_beat(make_beat(OP_PUSH, 8'h56, 8'd5, 8'h11, 1'b1, 3'd0));
    // bytes beyond the declared length
    send_beat(make_beat(OP_PUSH, 8'h78, 8'd1, 8'h20, 1'b0, 3'd0));
    send_beat(make_beat(OP_PUSH, 8'h78, 8'd1, 8'h21, 1'b0, 3'd0));
    send_beat(make_beat(OP_PUSH, 8'h78, 8'd1, 8'h22, 1'b1, 3'd0));
    repeat (3) send_beat(make_beat(OP_POP, 8'h00, 8'h00, 8'h00, 1'b0, 3'd0));
    send_beat(make_beat(OP_READ, 8'h00, 8'h00, 8'h00, 1'b0, 3'd0));
    send_beat(make_beat(OP_CLEAR, 8'h00, 8'h00, 8'h00, 1'b0, 3'd0));
    send_beat(make_beat(OP_READ, 8'h00, 8'h00, 8'h00, 1'b0, 3'd1));
    wait_for_drain();
  endtask

  // one source popped often enough for its count to roll over
  task automatic test_count_wrap();
    write_high_water(HIGH_WATER_RESET);
    repeat (260) begin
      send_beat(make_beat(OP_PUSH, 8'h5a, 8'd0, 8'($urandom), 1'b1, 3'd0));
      send_beat(make_beat(OP_POP, 8'h00, 8'h00, 8'h00, 1'b0, 3'd0));
    end
    for (int i = 0; i < TABLE_SIZE; i++)
      send_beat(make_beat(OP_READ, 8'h00, 8'h00, 8'h00, 1'b0, 3'(i)));
    wait_for_drain();
  endtask

  // fill every usable slot, push into a full ring, then empty it again
  task automatic test_fill_ring();
    write_high_water(5'd30);
    for (int i = 0; i < RING_SLOTS - 1; i++)
      send_beat(make_beat(OP_PUSH, 8'((i % 12) + 1), 8'd1, 8'($urandom), 1'b1, 3'd0));
    send_beat(make_beat(OP_PUSH, 8'h99, 8'd2, 8'h31, 1'b0, 3'd0));
    send_beat(make_beat(OP_PUSH, 8'h99, 8'd2, 8'h32, 1'b1, 3'd0));
    send_beat(make_beat(OP_PUSH, 8'h9a, 8'd0, 8'h33, 1'b1, 3'd0));
    repeat (RING_SLOTS) send_beat(make_beat(OP_POP, 8'h00, 8'h00, 8'h00, 1'b0, 3'd0));
    for (int i = 0; i < TABLE_SIZE; i++)
      send_beat(make_beat(OP_READ, 8'h00, 8'h00, 8'h00, 1'b0, 3'(i)));
    wait_for_drain();
  endtask

  task automatic run_random_traffic(input int n_beats, input int push_pct, input int pop_pct);
    int        stop_at, pick, len, n_items, k;
    logic [7:0] src;
    in_item_t  beat;
    stop_at = beats_sent + n_beats;
    while (beats_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < push_pct) begin
        // whole packet, mostly short, rarely full size or oversize
        k = $urandom_range(19);
        if (k < 12) len = $urandom_range(0, 6);
        else if (k < 17) len = $urandom_range(7, 40);
        else if (k == 17) len = $urandom_range(1) ? SLOT_LIMIT : $urandom_range(100, 127);
        else len = $urandom_range(129, 255);
        if (len > SLOT_LIMIT) begin
          n_items = $urandom_range(1, 3);
        end else begin
          n_items = (len == 0) ? 1 : len;
          k = $urandom_range(9);
          if (k == 0) n_items = $urandom_range(1, n_items);
          else if (k == 1) n_items += $urandom_range(1, 3);
        end
        src = ($urandom_range(7) == 0) ? 8'($urandom) : SOURCE_POOL[$urandom_range(11)];
        for (k = 0; k < n_items; k++) begin
          beat = random_beat();
          beat.op = OP_PUSH;
          beat.source_addr = src;
          beat.packet_length = 8'(len);
          beat.last = (k == n_items - 1);
          send_beat(beat);
        end
      end else if (pick < push_pct + pop_pct) begin
        // usually drain the head packet to its end
        n_items = 1;
        if (head_ptr != tail_ptr) n_items = int'(slot_len[head_ptr]) - rd_idx;
        if (n_items < 1) n_items = 1;
        if ($urandom_range(4) == 0) n_items = $urandom_range(1, 3);
        repeat (n_items) begin
          beat = random_beat();
          beat.op = OP_POP;
          send_beat(beat);
        end
      end else begin
        beat = random_beat();
        if (pick < push_pct + pop_pct + 6) beat.op = OP_READ;
        else if (pick < push_pct + pop_pct + 8) beat.op = OP_CLEAR;
        send_beat(beat);  // otherwise any beat at all
      end
    end
  endtask

  // receiver holds off for a long stretch while traffic keeps coming
  task automatic test_backpressure();
    write_high_water(5'($urandom_range(1, 30)));
    hold_requests++;
    run_random_traffic(40, 50, 30);
    wait_for_drain();
  endtask

  task automatic test_random();
    write_high_water(5'd31);
    idle_on = 1'b0;
    run_random_traffic(400, 45, 35);
    wait_for_drain();
    idle_on = 1'b1;
    write_high_water(5'($urandom));
    run_random_traffic(450, 55, 25);
    wait_for_drain();
    write_high_water(5'd5);
    run_random_traffic(450, 30, 50);
    wait_for_drain();
  endtask

  always @(negedge clk) begin
    if (hold_left == 0 && hold_requests != holds_served) begin
      hold_left = HOLD_CYCLES;
      holds_served++;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= idle_on && ($urandom_range(99) < 24);
    end
  end

  always @(posedge clk) begin : result_checker
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (queued_answers.size() == 0) begin
        $error("result beat with nothing expected: %h", out_data);
        error_count++;
      end else begin
        want = queued_answers.pop_front();
        compare_field("status", want.status, out_data.status);
        compare_field("out_byte", want.out_byte, out_data.out_byte);
        compare_field("out_source", want.out_source, out_data.out_source);
        compare_field("out_length", want.out_length, out_data.out_length);
        compare_field("end_of_packet", want.end_of_packet, out_data.end_of_packet);
        compare_field("occupancy", want.occupancy, out_data.occupancy);
        compare_field("over_threshold", want.over_threshold, out_data.over_threshold);
        compare_field("entry_addr", want.entry_addr, out_data.entry_addr);
        compare_field("entry_count", want.entry_count, out_data.entry_count);
        compare_field("modules_known", want.modules_known, out_data.modules_known);
        results_checked++;
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_count_wrap();
    test_fill_ring();
    test_backpressure();
    test_random();
    repeat (8) @(posedge clk);
    if (queued_answers.size() != 0) begin
      $error("%0d expected results never arrived", queued_answers.size());
      error_count++;
    end
    $display("covered %0d beats in, %0d results checked, %0d packets drained",
             beats_sent, results_checked, packets_popped);
    $display("refused pushes %0d, peak occupancy %0d, sources known %0d",
             pushes_refused, peak_occupancy, known_sources);
    if (error_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
